// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL in this folder.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: antecedent at one edge, consequent at the next edge.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mlpf_pkg.sv -----
// Shared constants, codes and the controller command struct for the PWM LED fader.
// No dependencies; imported by every module of the block.
package mlpf_pkg;

  localparam int CHANNELS  = 48;
  localparam int LED_W     = 48;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PERIOD_W  = 8;
  localparam int FADE_W    = 16;
  localparam int DUTY_W    = 8;
  localparam int PCT_W     = 7;
  localparam int PROD_W    = PERIOD_W + PCT_W;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd10;
  localparam logic [FADE_W-1:0]   FADE_RST   = 16'd40;
  localparam logic [DUTY_W-1:0]   DUTY_MIN   = 8'd1;
  localparam logic [DUTY_W-1:0]   DUTY_MAX   = 8'd100;

  // x / 100 == (x * 5243) >> 19, exact for x below 43690
  localparam int                 RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
  localparam int                 RECIP_SHIFT = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PWM_PERIOD    = 1'b0,
    REG_FADE_INTERVAL = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef struct packed {
    logic            start;     // input transaction taken this cycle
    logic            rd_en;     // tick sweep: read channel idx
    logic            wr_set;    // set sweep: write target of channel idx
    logic [CH_W-1:0] idx;
    logic            out_load;  // capture result into output register
  } mlpf_cmd_t;

endpackage

// ----- hdl/mlpf_dp.sv -----
// Datapath of the PWM LED fader: config registers, duty scaling, level memories,
// phase and fade counters, on-vector and output register. Uses mlpf_pkg.
module mlpf_dp import mlpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_op,
  input  logic [LED_W-1:0]     in_led_mask,
  input  logic [DUTY_W-1:0]    in_duty,
  input  mlpf_cmd_t            cmd,
  output logic [LED_W-1:0]     out_led_on
);

  logic [PERIOD_W-1:0] period_r;
  logic [FADE_W-1:0]   interval_r;
  logic [PERIOD_W-1:0] phase_r;
  logic [FADE_W-1:0]   cnt_r;
  logic                fade_r;
  logic [LED_W-1:0]    led_state_r;
  logic [LED_W-1:0]    out_led_on_r;
  logic [LED_W-1:0]    mask_r;
  logic [DUTY_W-1:0]   duty_r;
  logic [PROD_W-1:0]   prod_r;
  logic [PERIOD_W-1:0] lvl_r;

  logic [PERIOD_W-1:0] tgt_mem [CHANNELS];
  logic [PERIOD_W-1:0] cur_mem [CHANNELS];
  logic [CHANNELS-1:0] tgt_vld_r;
  logic [CHANNELS-1:0] cur_vld_r;
  logic [PERIOD_W-1:0] tgt_q_r;
  logic [PERIOD_W-1:0] cur_q_r;
  logic                tgt_qv_r;
  logic                cur_qv_r;
  logic                pv_r;
  logic [CH_W-1:0]     pidx_r;

  logic [PCT_W-1:0]            pct;
  logic [PROD_W+RECIP_W-1:0]   scaled;
  logic [PERIOD_W:0]           phase_inc;
  logic [PERIOD_W-1:0]         phase_nxt;
  logic [FADE_W-1:0]           cnt_dec;
  logic                        fade_nxt;
  logic [PERIOD_W-1:0]         tgt_eff;
  logic [PERIOD_W-1:0]         cur_eff;
  logic [PERIOD_W-1:0]         cur_step;
  logic                        tick_start;

  assign tick_start = cmd.start && (in_op == OP_TICK);

  // duty clamp to 1..100, then level = period * pct / 100 over two registered products
  always_comb begin
    if (duty_r > DUTY_MAX) begin
      pct = DUTY_MAX[PCT_W-1:0];
    end else if (duty_r < DUTY_MIN) begin
      pct = DUTY_MIN[PCT_W-1:0];
    end else begin
      pct = duty_r[PCT_W-1:0];
    end
  end

  assign scaled = (PROD_W+RECIP_W)'(prod_r) * (PROD_W+RECIP_W)'(RECIP_100);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(period_r) * PROD_W'(pct);
    lvl_r  <= scaled[RECIP_SHIFT +: PERIOD_W];
  end

  assign phase_inc = {1'b0, phase_r} + 1'b1;
  assign phase_nxt = (phase_inc > {1'b0, period_r}) ? '0 : phase_inc[PERIOD_W-1:0];
  assign cnt_dec   = cnt_r - 1'b1;
  assign fade_nxt  = (cnt_dec == '0);

  assign tgt_eff = tgt_qv_r ? tgt_q_r : '0;
  assign cur_eff = cur_qv_r ? cur_q_r : '0;

  always_comb begin
    if (tgt_eff > cur_eff) begin
      cur_step = cur_eff + 1'b1;
    end else if (tgt_eff < cur_eff) begin
      cur_step = cur_eff - 1'b1;
    end else begin
      cur_step = cur_eff;
    end
  end

  // level memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (cmd.wr_set) begin
      tgt_mem[cmd.idx] <= mask_r[cmd.idx] ? lvl_r : '0;
    end
    if (pv_r && fade_r) begin
      cur_mem[pidx_r] <= cur_step;
    end
    if (cmd.rd_en) begin
      tgt_q_r <= tgt_mem[cmd.idx];
      cur_q_r <= cur_mem[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mask_r <= in_led_mask;
      duty_r <= in_duty;
    end
    if (cmd.rd_en) begin
      pidx_r <= cmd.idx;
    end
    if (cmd.out_load) begin
      out_led_on_r <= led_state_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RST;
      interval_r  <= FADE_RST;
      phase_r     <= PERIOD_RST;
      cnt_r       <= FADE_RST;
      fade_r      <= 1'b0;
      led_state_r <= '0;
      tgt_vld_r   <= '0;
      cur_vld_r   <= '0;
      tgt_qv_r    <= 1'b0;
      cur_qv_r    <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PWM_PERIOD:    period_r   <= cfg_wdata[PERIOD_W-1:0];
          REG_FADE_INTERVAL: interval_r <= cfg_wdata[FADE_W-1:0];
          default: ;
        endcase
      end
      if (tick_start) begin
        phase_r     <= phase_nxt;
        cnt_r       <= fade_nxt ? interval_r : cnt_dec;
        fade_r      <= fade_nxt;
        led_state_r <= '0;
      end
      pv_r <= cmd.rd_en;
      if (cmd.rd_en) begin
        tgt_qv_r <= tgt_vld_r[cmd.idx];
        cur_qv_r <= cur_vld_r[cmd.idx];
      end
      if (cmd.wr_set) begin
        tgt_vld_r[cmd.idx] <= 1'b1;
      end
      if (pv_r) begin
        // compare uses the level before this tick's fade step
        led_state_r[pidx_r] <= (phase_r < cur_eff);
        if (fade_r) begin
          cur_vld_r[pidx_r] <= 1'b1;
        end
      end
    end
  end

  assign out_led_on = out_led_on_r;

endmodule

// ----- hdl/mlpf_ctrl.sv -----
// Controller of the PWM LED fader: sequences scaling, the channel sweep
// and the result handoff. Uses mlpf_pkg; drives mlpf_dp through mlpf_cmd_t.
module mlpf_ctrl import mlpf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output mlpf_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE_A,
    S_SCALE_B,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_t;

  localparam logic [CH_W-1:0] LAST_IDX = CH_W'(CHANNELS - 1);

  state_t          state_r;
  op_t             op_r;
  logic [CH_W-1:0] idx_r;
  logic            out_valid_r;

  always_comb begin
    cmd.start    = in_valid && (state_r == S_IDLE);
    cmd.rd_en    = (state_r == S_SWEEP) && (op_r == OP_TICK);
    cmd.wr_set   = (state_r == S_SWEEP) && (op_r == OP_SET);
    cmd.idx      = idx_r;
    cmd.out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_TICK;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          idx_r <= '0;
          if (in_valid) begin
            op_r    <= op_t'(in_op);
            state_r <= (in_op == OP_SET) ? S_SCALE_A : S_SWEEP;
          end
        end
        S_SCALE_A: state_r <= S_SCALE_B;
        S_SCALE_B: state_r <= S_SWEEP;
        S_SWEEP: begin
          if (idx_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DRAIN: state_r <= S_DONE;
        S_DONE: begin
          if (cmd.out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/multichannel_led_pwm_fader_core.sv -----
// Multichannel PWM LED fader with soft fade.
// Input channel (in_valid/in_stall): in_op selects a PWM tick or a target set
// from in_led_mask and in_duty. Every transaction yields one result transaction
// on out_valid/out_stall carrying the 48-bit LED on-vector out_led_on.
// A tick advances the PWM phase, updates the fade countdown and sweeps the
// level memories one channel per cycle; a set scales the duty through two
// registered multiplies and then writes one target per cycle.
// Sequence: a tick runs the channel sweep, a drain state and the done state; a set
// first runs the two scale states. out_valid rises when the done state loads the
// output register. Most of a transaction's time is the channel sweep over the
// level memories; one transaction is in work at a time, and the controller
// returns to idle and takes the next one once the result enters the output
// register, even while that result is stalled.
// A stalled result holds out_led_on steady; a finished transaction waits in
// the controller until the output register is free.
// Reset (rst_n low, synchronous) restores period 10, fade interval 40, phase
// 10, all levels zero and all LED states off; no clearing pass is needed.
// Configuration: cfg_we writes cfg_wdata to cfg_index (0 = PWM period, 1 = fade
// interval); the user must write only while the block is idle (not enforced).
module multichannel_led_pwm_fader_core import mlpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [LED_W-1:0]     in_led_mask,
  input  logic [DUTY_W-1:0]    in_duty,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LED_W-1:0]     out_led_on
);

  `include "assert_macros.svh"

  mlpf_cmd_t cmd;

  mlpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  mlpf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_op       (in_op),
    .in_led_mask (in_led_mask),
    .in_duty     (in_duty),
    .cmd         (cmd),
    .out_led_on  (out_led_on)
  );

  `CHK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted twice in a row")
  `CHK_ALWAYS(a_result_after_work, !$rose(out_valid) || $past(in_stall), "result without work")
  `CHK_ALWAYS(a_load_when_free, !cmd.out_load || !$past(out_valid) || !out_stall || !out_valid, "output overwritten")
  `CHK_ALWAYS(a_sweep_one_kind, !(cmd.rd_en && cmd.wr_set), "tick and set sweep overlap")

endmodule
